>>> rtl/core/pta_pkg.sv
// Package for the page table allocator.
// Holds the transaction payload types, table entry layout, codes and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package pta_pkg;

  // Stack runs start this many pages below the stack base
  localparam int unsigned STACK_LOW_PAGES = 2;

  // Configuration register indexes
  localparam logic [1:0] CFG_HEAP_TOP   = 2'd0;
  localparam logic [1:0] CFG_STACK_BASE = 2'd1;
  localparam logic [1:0] CFG_REAL_BASE  = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FAIL     = 2'd1;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

  typedef enum logic [1:0] {
    KIND_FREE  = 2'd0,
    KIND_HEAP  = 2'd1,
    KIND_STACK = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_V2R   = 2'd2,
    OP_R2V   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RES_ADDR,
    RES_ZERO,
    RES_FAIL,
    RES_NOTFOUND
  } res_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_R2V_WAIT,
    S_SCAN,
    S_FRESH,
    S_WALK_RD,
    S_WALK_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic        kind;
    logic [3:0]  page_count;
    logic [15:0] owner_id;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] va;
    logic [3:0]  run_len;
    logic [15:0] owner;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic req_load;
    logic scan_start;
    logic scan_step;
    logic r2v_rd;
    logic r2v_cap;
    logic walk_init;
    logic walk_fresh;
    logic walk_rd;
    logic walk_wr;
    logic res_load;
    res_e res_kind;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_e  op;
    logic clr_last;
    logic bad_cnt;
    logic r2v_oob;
    logic hit;
    logic scan_last;
    logic fresh_ok;
    logic walk_last;
    logic out_free;
  } stat_t;

endpackage

>>> rtl/core/page_table_allocator.sv
// Page table allocator: allocate and free page runs, translate virtual to
// real and back over a table of POOL_ENTRIES entries held in one single-port
// memory. After reset the block clears the whole table and
// takes no transaction meanwhile (configuration writes are taken). One
// transaction is worked at a time. Allocate, free and virtual-to-real
// scan the table one entry per cycle, and each page that an allocate or
// free writes back takes a read-modify-write on the same memory port.
// The next transaction is accepted while a finished result still waits
// in the output register.
`timescale 1ns / 1ps

module page_table_allocator #(
  parameter int POOL_ENTRIES = 64,
  parameter int MAX_RUN      = 8,
  parameter int PAGE_SHIFT   = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pta_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pta_pkg::out_item_t out_item_o
);

  pta_pkg::cmd_t  cmd;
  pta_pkg::stat_t stat;

  // Registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  pta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pta_datapath #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .MAX_RUN      (MAX_RUN),
    .PAGE_SHIFT   (PAGE_SHIFT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

>>> rtl/core/pta_ctrl.sv
// Controller state machine of the page table allocator.
// Sequences clear, check, scan, fresh, walk, real-to-virtual and result steps; uses pta_pkg types.
`timescale 1ns / 1ps

module pta_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pta_pkg::stat_t stat_i,
  output pta_pkg::cmd_t  cmd_o
);

  pta_pkg::state_e state_q, state_d;
  pta_pkg::res_e   res_kind_q, res_kind_d;

  // State and pending result kind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pta_pkg::S_CLEAR;
      res_kind_q <= pta_pkg::RES_ZERO;
    end else begin
      state_q    <= state_d;
      res_kind_q <= res_kind_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    res_kind_d = res_kind_q;
    cmd_o      = '0;
    cmd_o.res_kind = res_kind_q;
    in_stall_o = (state_q != pta_pkg::S_IDLE);
    case (state_q)
      pta_pkg::S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = pta_pkg::S_IDLE;
      end
      pta_pkg::S_IDLE: begin
        cmd_o.req_load = in_valid_i;
        if (in_valid_i) state_d = pta_pkg::S_CHECK;
      end
      pta_pkg::S_CHECK: begin
        case (stat_i.op)
          pta_pkg::OP_ALLOC, pta_pkg::OP_FREE: begin
            if (stat_i.bad_cnt) begin
              res_kind_d = pta_pkg::RES_FAIL;
              state_d    = pta_pkg::S_DONE;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = pta_pkg::S_SCAN;
            end
          end
          pta_pkg::OP_V2R: begin
            cmd_o.scan_start = 1'b1;
            state_d          = pta_pkg::S_SCAN;
          end
          default: begin
            if (stat_i.r2v_oob) begin
              res_kind_d = pta_pkg::RES_NOTFOUND;
              state_d    = pta_pkg::S_DONE;
            end else begin
              cmd_o.r2v_rd = 1'b1;
              state_d      = pta_pkg::S_R2V_WAIT;
            end
          end
        endcase
      end
      pta_pkg::S_R2V_WAIT: begin
        cmd_o.r2v_cap = 1'b1;
        res_kind_d    = pta_pkg::RES_ADDR;
        state_d       = pta_pkg::S_DONE;
      end
      pta_pkg::S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.hit) begin
          if (stat_i.op == pta_pkg::OP_V2R) begin
            res_kind_d = pta_pkg::RES_ADDR;
            state_d    = pta_pkg::S_DONE;
          end else begin
            cmd_o.walk_init = 1'b1;
            state_d         = pta_pkg::S_WALK_RD;
          end
        end else if (stat_i.scan_last) begin
          if (stat_i.op == pta_pkg::OP_ALLOC) begin
            state_d = pta_pkg::S_FRESH;
          end else begin
            res_kind_d = pta_pkg::RES_NOTFOUND;
            state_d    = pta_pkg::S_DONE;
          end
        end
      end
      pta_pkg::S_FRESH: begin
        if (stat_i.fresh_ok) begin
          cmd_o.walk_init  = 1'b1;
          cmd_o.walk_fresh = 1'b1;
          state_d          = pta_pkg::S_WALK_RD;
        end else begin
          res_kind_d = pta_pkg::RES_FAIL;
          state_d    = pta_pkg::S_DONE;
        end
      end
      pta_pkg::S_WALK_RD: begin
        cmd_o.walk_rd = 1'b1;
        state_d       = pta_pkg::S_WALK_WR;
      end
      pta_pkg::S_WALK_WR: begin
        cmd_o.walk_wr = 1'b1;
        if (stat_i.walk_last) begin
          res_kind_d = (stat_i.op == pta_pkg::OP_ALLOC) ? pta_pkg::RES_ADDR
                                                        : pta_pkg::RES_ZERO;
          state_d    = pta_pkg::S_DONE;
        end else begin
          state_d = pta_pkg::S_WALK_RD;
        end
      end
      pta_pkg::S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = pta_pkg::S_IDLE;
        end
      end
      default: state_d = pta_pkg::S_IDLE;
    endcase
  end

endmodule

>>> rtl/core/pta_datapath.sv
// Datapath of the page table allocator: entry table memory, scan and walk
// counters, configuration registers and output register. Uses pta_pkg.
`timescale 1ns / 1ps

module pta_datapath #(
  parameter int POOL_ENTRIES = 64,
  parameter int MAX_RUN      = 8,
  parameter int PAGE_SHIFT   = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  pta_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pta_pkg::out_item_t out_item_o,
  input  pta_pkg::cmd_t      cmd_i,
  output pta_pkg::stat_t     stat_o
);

  localparam int IW = $clog2(POOL_ENTRIES);
  localparam int PW = $clog2(POOL_ENTRIES + 1);

  pta_pkg::entry_t mem_q [POOL_ENTRIES];
  pta_pkg::entry_t rd_data_q, wr_data;
  logic [IW-1:0]   rd_addr, wr_addr;
  logic            rd_en, wr_en;

  logic [31:0] heap_top_q, stack_base_q, real_base_q;
  pta_pkg::in_item_t req_q;
  logic [PW-1:0] issued_q, clr_cnt_q, scan_ptr_q;
  logic [IW-1:0] rd_idx_q, fresh_idx_q, walk_e_q;
  logic          rd_vld_q, fresh_found_q, walk_fresh_q, out_valid_q;
  logic [3:0]    walk_k_q;
  logic [31:0]   res_addr_q;
  pta_pkg::out_item_t out_q;

  pta_pkg::op_e op;
  logic [3:0]   cnt;
  logic [31:0]  r2v_idx;
  logic         scan_more, match, heap_fresh;

  assign op        = pta_pkg::op_e'(req_q.op);
  assign cnt       = req_q.page_count;
  assign r2v_idx   = (req_q.address - real_base_q) >> PAGE_SHIFT;
  assign scan_more = (scan_ptr_q < PW'(POOL_ENTRIES));
  assign heap_fresh = walk_fresh_q && !req_q.kind;

  // Match rule of the current scan, per operation
  always_comb begin
    case (op)
      pta_pkg::OP_ALLOC:
        match = (rd_data_q.run_len == cnt) && (rd_data_q.kind == pta_pkg::KIND_FREE)
             && (32'(rd_idx_q) + 32'(cnt) <= 32'(POOL_ENTRIES));
      pta_pkg::OP_FREE:
        match = (PW'(rd_idx_q) < issued_q) && (rd_data_q.va == req_q.address)
             && (rd_data_q.kind == pta_pkg::KIND_HEAP);
      pta_pkg::OP_V2R:
        match = (rd_data_q.va == req_q.address)
             && ((rd_data_q.kind == pta_pkg::KIND_HEAP)
              || ((rd_data_q.kind == pta_pkg::KIND_STACK)
               && (rd_data_q.owner == req_q.owner_id)));
      default: match = 1'b0;
    endcase
  end

  always_comb begin
    stat_o.op        = op;
    stat_o.clr_last  = (clr_cnt_q == PW'(POOL_ENTRIES - 1));
    stat_o.bad_cnt   = (cnt == 4'd0) || (32'(cnt) > 32'(MAX_RUN));
    stat_o.r2v_oob   = (r2v_idx >= 32'(POOL_ENTRIES));
    stat_o.hit       = rd_vld_q && match;
    stat_o.scan_last = rd_vld_q && (rd_idx_q == IW'(POOL_ENTRIES - 1));
    stat_o.fresh_ok  = fresh_found_q
                    && (32'(fresh_idx_q) + 32'(cnt) <= 32'(POOL_ENTRIES));
    stat_o.walk_last = (walk_k_q == cnt - 4'd1)
                    || ((op == pta_pkg::OP_FREE) && (walk_e_q == '0));
    stat_o.out_free  = !out_valid_q || !out_stall_i;
  end

  // Memory port selection and write data
  always_comb begin
    rd_en   = (cmd_i.scan_step && scan_more) || cmd_i.walk_rd || cmd_i.r2v_rd;
    rd_addr = cmd_i.scan_step ? scan_ptr_q[IW-1:0]
            : (cmd_i.walk_rd ? walk_e_q : r2v_idx[IW-1:0]);
    wr_en   = cmd_i.clr_wr || cmd_i.walk_wr;
    wr_addr = cmd_i.clr_wr ? clr_cnt_q[IW-1:0] : walk_e_q;
    wr_data = rd_data_q;
    if (cmd_i.clr_wr) begin
      wr_data = '0;
    end else if (op == pta_pkg::OP_ALLOC) begin
      wr_data.kind    = req_q.kind ? pta_pkg::KIND_STACK : pta_pkg::KIND_HEAP;
      wr_data.run_len = cnt;
      wr_data.owner   = req_q.owner_id;
      if (req_q.kind) begin
        wr_data.va = stack_base_q + (32'(walk_k_q) << PAGE_SHIFT)
                   - (32'(pta_pkg::STACK_LOW_PAGES) << PAGE_SHIFT);
      end else if (walk_fresh_q) begin
        wr_data.va = heap_top_q
                   - ((32'(issued_q) + 32'(walk_k_q) + 32'd1) << PAGE_SHIFT);
      end
    end else begin
      wr_data.kind    = pta_pkg::KIND_FREE;
      wr_data.run_len = cnt;
      wr_data.owner   = '0;
    end
  end

  // Entry table
  always_ff @(posedge clk_i) begin
    if (rd_en) rd_data_q <= mem_q[rd_addr];
    if (wr_en) mem_q[wr_addr] <= wr_data;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_top_q   <= '0;
      stack_base_q <= '0;
      real_base_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pta_pkg::CFG_HEAP_TOP:   heap_top_q   <= cfg_data_i;
        pta_pkg::CFG_STACK_BASE: stack_base_q <= cfg_data_i;
        pta_pkg::CFG_REAL_BASE:  real_base_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q     <= '0;
      issued_q      <= '0;
      scan_ptr_q    <= '0;
      rd_vld_q      <= 1'b0;
      fresh_found_q <= 1'b0;
      walk_fresh_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_cnt_q <= clr_cnt_q + PW'(1);
      rd_vld_q <= cmd_i.scan_step && scan_more;
      if (cmd_i.scan_start) begin
        scan_ptr_q    <= '0;
        fresh_found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        if (scan_more) scan_ptr_q <= scan_ptr_q + PW'(1);
        if (rd_vld_q && !fresh_found_q && rd_data_q.run_len == 4'd0) begin
          fresh_found_q <= 1'b1;
        end
      end
      if (cmd_i.walk_init) walk_fresh_q <= cmd_i.walk_fresh;
      if (cmd_i.walk_wr && stat_o.walk_last && op == pta_pkg::OP_ALLOC && heap_fresh) begin
        issued_q <= issued_q + PW'(cnt);
      end
      if (cmd_i.res_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Request, scan and walk payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) req_q <= in_item_i;
    rd_idx_q <= scan_ptr_q[IW-1:0];
    if (cmd_i.scan_step && rd_vld_q && !fresh_found_q && rd_data_q.run_len == 4'd0) begin
      fresh_idx_q <= rd_idx_q;
    end
    if (cmd_i.scan_step && stat_o.hit && op == pta_pkg::OP_V2R) begin
      res_addr_q <= real_base_q + (32'(rd_idx_q) << PAGE_SHIFT);
    end
    if (cmd_i.r2v_cap) res_addr_q <= rd_data_q.va;
    if (cmd_i.walk_init) begin
      walk_e_q <= cmd_i.walk_fresh ? fresh_idx_q : rd_idx_q;
      walk_k_q <= '0;
    end else if (cmd_i.walk_wr) begin
      walk_k_q <= walk_k_q + 4'd1;
      walk_e_q <= (op == pta_pkg::OP_ALLOC) ? walk_e_q + IW'(1) : walk_e_q - IW'(1);
      if (op == pta_pkg::OP_ALLOC) begin
        if (req_q.kind) res_addr_q <= stack_base_q;
        else if (walk_fresh_q)
          res_addr_q <= heap_top_q - ((32'(issued_q) + 32'(cnt)) << PAGE_SHIFT);
        else res_addr_q <= rd_data_q.va;
      end
    end
    if (cmd_i.res_load) begin
      case (cmd_i.res_kind)
        pta_pkg::RES_ADDR: begin
          out_q.result_address <= res_addr_q;
          out_q.status         <= pta_pkg::STATUS_OK;
        end
        pta_pkg::RES_ZERO: begin
          out_q.result_address <= '0;
          out_q.status         <= pta_pkg::STATUS_OK;
        end
        pta_pkg::RES_FAIL: begin
          out_q.result_address <= '0;
          out_q.status         <= pta_pkg::STATUS_FAIL;
        end
        default: begin
          out_q.result_address <= '0;
          out_q.status         <= pta_pkg::STATUS_NOTFOUND;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Heap counter never passes the table size
  a_issued_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issued_q <= PW'(POOL_ENTRIES))
    else $error("heap page count beyond table size");

  // Scan data is only evaluated after a scan read
  a_rd_vld_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(cmd_i.scan_step))
    else $error("scan data valid without scan read");

  // Every walk write is preceded by its read
  a_walk_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_wr |-> $past(cmd_i.walk_rd))
    else $error("walk write without prior read");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten");

endmodule
